FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check that is switched off while reset is held
`define PIDM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds through reset
`define PIDM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/pidm_pkg.sv
// shared types, widths and constants of the multi-mode pid controller
`default_nettype none

package pidm_pkg;

    // sample and register widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int GAIN_SCALE   = 1000;
    localparam int GAIN_W       = 16;
    localparam int LIMIT_W      = 20;
    localparam int CFG_DATA_W   = 20;
    localparam int CFG_IDX_W    = 3;
    localparam int DRIVE_W      = 32;
    localparam int SUM_W        = 32;
    localparam int SUM_EXT_W    = SUM_W + 1;

    // error and difference terms
    localparam int ERR_W   = SAMPLE_WIDTH + 1;
    localparam int PTERM_W = SAMPLE_WIDTH + 2;
    localparam int DTERM_W = SAMPLE_WIDTH + 3;
    localparam int BAND_W  = ((ERR_W > GAIN_W) ? ERR_W : GAIN_W) + 1;

    // gain products and their sum
    localparam int PROD_P_W = PTERM_W + GAIN_W + 1;
    localparam int PROD_I_W = SUM_W + GAIN_W + 1;
    localparam int PROD_D_W = DTERM_W + GAIN_W + 1;
    localparam int ACC_W    = PROD_I_W + 2;

    // scaling by reciprocal multiplication
    localparam int MAG_W      = DRIVE_W + $clog2(GAIN_SCALE);
    localparam int DIV_SHIFT  = MAG_W + $clog2(GAIN_SCALE);
    localparam int RECIP_W    = MAG_W + 1;
    localparam int SPLIT_W    = 24;
    localparam int MAG_HI_W   = MAG_W - SPLIT_W;
    localparam int RECIP_HI_W = RECIP_W - SPLIT_W;
    localparam int PROD_W     = MAG_W + RECIP_W;

    localparam logic [MAG_W-1:0] MAG_MAX =
        MAG_W'(64'(GAIN_SCALE) << (DRIVE_W - 1));
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((65'd1 << DIV_SHIFT) + 65'(GAIN_SCALE) - 65'd1) / 65'(GAIN_SCALE));
    localparam logic [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W - 1){1'b1}}};

    // error sum limits for saturation
    localparam logic signed [SUM_EXT_W-1:0] SUM_HI =
        SUM_EXT_W'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
    localparam logic signed [SUM_EXT_W-1:0] SUM_LO = -SUM_HI - SUM_EXT_W'(1);

    // work queue and back pipeline depth
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int BACK_STAGES  = 6;
    localparam int MAX_INFLIGHT = Q_DEPTH + BACK_STAGES;
    localparam int INFLIGHT_W   = $clog2(MAX_INFLIGHT + 1);

    // register reset values
    localparam logic [LIMIT_W-1:0] RST_LIMIT     = LIMIT_W'(6000);
    localparam logic [GAIN_W-1:0]  RST_THRESHOLD = GAIN_W'(30);

    typedef enum logic [1:0] {
        MODE_INCR  = 2'd0,
        MODE_CLAMP = 2'd1,
        MODE_BAND  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE           = 3'd0,
        REG_GAIN_P         = 3'd1,
        REG_GAIN_I         = 3'd2,
        REG_GAIN_D         = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_BAND_THRESHOLD = 3'd5,
        REG_GAIN_I_BAND    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        t_mode               mode;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [LIMIT_W-1:0]  integral_limit;
        logic [GAIN_W-1:0]   band_threshold;
        logic [GAIN_W-1:0]   gain_i_band;
    } t_cfg;

    // one classified word handed from front to back
    typedef struct packed {
        logic [PTERM_W-1:0] p_term;
        logic [SUM_W-1:0]   i_term;
        logic [DTERM_W-1:0] d_term;
        logic [GAIN_W-1:0]  gain_i;
    } t_work;

    // queue handshake towards the front
    typedef struct packed {
        logic push;
        logic full;
    } t_q_front;

    // queue handshake towards the back
    typedef struct packed {
        logic pop;
        logic empty;
    } t_q_back;

endpackage

`default_nettype wire

FILE: src/pid_controller_multi_mode_top.sv
// Multi-mode PID controller: one drive word per target/measured word.
// Input channel i_valid/o_ready carries i_target and i_measured (signed).
// Output channel o_valid/i_ready carries o_drive, signed 32-bit, saturated.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at the
// clock edge (0 mode, 1 gain_p, 2 gain_i, 3 gain_d, 4 integral_limit,
// 5 band_threshold, 6 gain_i_band); write only while no word is in flight.
// Throughput: one word per cycle while o_ready is high. The front updates error history and sum
// in the cycle a word is taken, so the next word can follow at once.
// Path to o_valid: queue slot, product, sum and magnitude stages, two
// reciprocal scaling stages, output register.
// Receiver stall: the back pipeline freezes; the two-entry queue keeps
// taking words until full, then o_ready drops until the stall clears.
// Reset (synchronous, i_rst_n low): queue and pipeline empty, history and
// error sum zero, mode 1, gains 0, limit 6000, band threshold 30.
`default_nettype none

module pid_controller_multi_mode_top (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_valid,
    output logic                                          o_ready,
    input  wire logic signed [pidm_pkg::SAMPLE_WIDTH-1:0] i_target,
    input  wire logic signed [pidm_pkg::SAMPLE_WIDTH-1:0] i_measured,
    output logic                                          o_valid,
    input  wire logic                                     i_ready,
    output logic signed [pidm_pkg::DRIVE_W-1:0]           o_drive,
    input  wire logic                                     i_cfg_we,
    input  wire logic [pidm_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  wire logic [pidm_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    pidm_pkg::t_cfg     r_cfg, n_cfg;
    pidm_pkg::t_q_front q_front;
    pidm_pkg::t_q_back  q_back;
    pidm_pkg::t_work    front_word;
    pidm_pkg::t_work    back_word;
    logic               q_full;
    logic               back_pop;

    // configuration register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (pidm_pkg::t_reg_idx'(i_cfg_idx))
                pidm_pkg::REG_MODE:
                    n_cfg.mode = pidm_pkg::t_mode'(i_cfg_data[1:0]);
                pidm_pkg::REG_GAIN_P:
                    n_cfg.gain_p = i_cfg_data[pidm_pkg::GAIN_W-1:0];
                pidm_pkg::REG_GAIN_I:
                    n_cfg.gain_i = i_cfg_data[pidm_pkg::GAIN_W-1:0];
                pidm_pkg::REG_GAIN_D:
                    n_cfg.gain_d = i_cfg_data[pidm_pkg::GAIN_W-1:0];
                pidm_pkg::REG_INTEGRAL_LIMIT:
                    n_cfg.integral_limit = i_cfg_data[pidm_pkg::LIMIT_W-1:0];
                pidm_pkg::REG_BAND_THRESHOLD:
                    n_cfg.band_threshold = i_cfg_data[pidm_pkg::GAIN_W-1:0];
                pidm_pkg::REG_GAIN_I_BAND:
                    n_cfg.gain_i_band = i_cfg_data[pidm_pkg::GAIN_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= pidm_pkg::MODE_CLAMP;
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.integral_limit <= pidm_pkg::RST_LIMIT;
            r_cfg.band_threshold <= pidm_pkg::RST_THRESHOLD;
            r_cfg.gain_i_band    <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front: error, history and sum
    pidm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_target   (i_target),
        .i_measured (i_measured),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_q        (q_front),
        .o_word     (front_word)
    );

    // work queue
    pidm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_front (q_front),
        .i_word  (front_word),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_back  (q_back),
        .o_word  (back_word)
    );

    // back: products, scaling, saturation, output register
    pidm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_q     (q_back),
        .i_word  (back_word),
        .o_pop   (back_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_drive (o_drive)
    );

endmodule

`default_nettype wire

FILE: src/pidm_front.sv
// front part: takes a word, forms the error, updates history and sum
`default_nettype none

module pidm_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [pidm_pkg::SAMPLE_WIDTH-1:0] i_target,
    input  wire logic signed [pidm_pkg::SAMPLE_WIDTH-1:0] i_measured,
    input  wire pidm_pkg::t_cfg                        i_cfg,
    input  wire logic                                  i_q_full,
    output pidm_pkg::t_q_front                         o_q,
    output pidm_pkg::t_work                            o_word
);

    logic signed [pidm_pkg::ERR_W-1:0]     r_err1, n_err1;
    logic signed [pidm_pkg::ERR_W-1:0]     r_err2, n_err2;
    logic signed [pidm_pkg::SUM_W-1:0]     r_sum, n_sum;
    logic signed [pidm_pkg::ERR_W-1:0]     err;
    logic signed [pidm_pkg::PTERM_W-1:0]   diff1;
    logic signed [pidm_pkg::DTERM_W-1:0]   diff2;
    logic signed [pidm_pkg::SUM_EXT_W-1:0] sum_wide;
    logic signed [pidm_pkg::SUM_EXT_W-1:0] lim;
    logic signed [pidm_pkg::SUM_EXT_W-1:0] sum_clamp;
    logic signed [pidm_pkg::SUM_EXT_W-1:0] sum_sat;
    logic signed [pidm_pkg::BAND_W-1:0]    err_band;
    logic signed [pidm_pkg::BAND_W-1:0]    thr;
    logic                                  outside;
    logic                                  accept;

    assign accept   = i_valid && !i_q_full;
    assign o_ready  = !i_q_full;
    assign o_q.push = accept;
    assign o_q.full = i_q_full;

    // error, differences and candidate sums
    always_comb begin
        err      = pidm_pkg::ERR_W'(i_target) - pidm_pkg::ERR_W'(i_measured);
        diff1    = pidm_pkg::PTERM_W'(err) - pidm_pkg::PTERM_W'(r_err1);
        diff2    = pidm_pkg::DTERM_W'(err) - (pidm_pkg::DTERM_W'(r_err1) <<< 1)
                 + pidm_pkg::DTERM_W'(r_err2);
        sum_wide = pidm_pkg::SUM_EXT_W'(r_sum) + pidm_pkg::SUM_EXT_W'(err);
        lim      = $signed(pidm_pkg::SUM_EXT_W'(i_cfg.integral_limit));
        if (sum_wide > lim) begin
            sum_clamp = lim;
        end else if (sum_wide < -lim) begin
            sum_clamp = -lim;
        end else begin
            sum_clamp = sum_wide;
        end
        if (sum_wide > pidm_pkg::SUM_HI) begin
            sum_sat = pidm_pkg::SUM_HI;
        end else if (sum_wide < pidm_pkg::SUM_LO) begin
            sum_sat = pidm_pkg::SUM_LO;
        end else begin
            sum_sat = sum_wide;
        end
        err_band = pidm_pkg::BAND_W'(err);
        thr      = $signed(pidm_pkg::BAND_W'(i_cfg.band_threshold));
        outside  = (err_band > thr) || (err_band < -thr);
    end

    // classify by mode into one work word and the next state
    always_comb begin
        n_err1 = r_err1;
        n_err2 = r_err2;
        n_sum  = r_sum;
        o_word = '0;
        case (i_cfg.mode)
            pidm_pkg::MODE_INCR: begin
                o_word.p_term = diff1;
                o_word.i_term = pidm_pkg::SUM_W'(err);
                o_word.d_term = diff2;
                o_word.gain_i = i_cfg.gain_i;
                n_err2        = r_err1;
                n_err1        = err;
            end
            pidm_pkg::MODE_CLAMP: begin
                o_word.p_term = pidm_pkg::PTERM_W'(err);
                o_word.i_term = pidm_pkg::SUM_W'(sum_clamp);
                o_word.d_term = pidm_pkg::DTERM_W'(diff1);
                o_word.gain_i = i_cfg.gain_i;
                n_sum         = pidm_pkg::SUM_W'(sum_clamp);
                n_err1        = err;
            end
            pidm_pkg::MODE_BAND: begin
                o_word.p_term = pidm_pkg::PTERM_W'(err);
                o_word.i_term = pidm_pkg::SUM_W'(sum_sat);
                o_word.d_term = pidm_pkg::DTERM_W'(diff1);
                o_word.gain_i = outside ? i_cfg.gain_i : i_cfg.gain_i_band;
                n_sum         = pidm_pkg::SUM_W'(sum_sat);
                n_err1        = err;
            end
            default: begin
                // unused mode: all terms zero, state kept
                o_word = '0;
            end
        endcase
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err1 <= '0;
            r_err2 <= '0;
            r_sum  <= '0;
        end else if (accept) begin
            r_err1 <= n_err1;
            r_err2 <= n_err2;
            r_sum  <= n_sum;
        end
    end

endmodule

`default_nettype wire

FILE: src/pidm_queue.sv
// short work queue between the front and back parts
`default_nettype none

module pidm_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pidm_pkg::t_q_front  i_front,
    input  wire pidm_pkg::t_work     i_word,
    output logic                     o_full,
    input  wire logic                i_pop,
    output pidm_pkg::t_q_back        o_back,
    output pidm_pkg::t_work          o_word
);

    pidm_pkg::t_work            r_mem [pidm_pkg::Q_DEPTH];
    logic [pidm_pkg::Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [pidm_pkg::Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [pidm_pkg::Q_PTR_W:0]   r_count, n_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full       = (r_count == (pidm_pkg::Q_PTR_W + 1)'(pidm_pkg::Q_DEPTH));
    assign o_back.empty = (r_count == '0);
    assign o_back.pop   = do_pop;
    assign o_word       = r_mem[r_rd_ptr];
    assign do_push      = i_front.push && !o_full;
    assign do_pop       = i_pop && !o_back.empty;

    // pointer and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == pidm_pkg::Q_PTR_W'(pidm_pkg::Q_DEPTH - 1))
                     ? '0 : r_wr_ptr + pidm_pkg::Q_PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == pidm_pkg::Q_PTR_W'(pidm_pkg::Q_DEPTH - 1))
                     ? '0 : r_rd_ptr + pidm_pkg::Q_PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + (pidm_pkg::Q_PTR_W + 1)'(1);
            2'b01:   n_count = r_count - (pidm_pkg::Q_PTR_W + 1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

`default_nettype wire

FILE: src/pidm_back.sv
// back part: gain products, sum, scaling by the gain scale, saturation
`default_nettype none

module pidm_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pidm_pkg::t_cfg                i_cfg,
    input  wire pidm_pkg::t_q_back             i_q,
    input  wire pidm_pkg::t_work               i_word,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [pidm_pkg::DRIVE_W-1:0] o_drive
);

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic adv;

    logic signed [pidm_pkg::PROD_P_W-1:0] r_prod_p, n_prod_p;
    logic signed [pidm_pkg::PROD_I_W-1:0] r_prod_i, n_prod_i;
    logic signed [pidm_pkg::PROD_D_W-1:0] r_prod_d, n_prod_d;
    logic signed [pidm_pkg::ACC_W-1:0]    r_acc;
    logic [pidm_pkg::ACC_W-1:0]           mag_full;
    logic [pidm_pkg::MAG_W-1:0]           r_mag;
    logic                                 r_neg3, r_neg4, r_neg5;
    logic [2*pidm_pkg::SPLIT_W-1:0]                        r_pll;
    logic [pidm_pkg::SPLIT_W+pidm_pkg::RECIP_HI_W-1:0]     r_plh;
    logic [pidm_pkg::MAG_HI_W+pidm_pkg::SPLIT_W-1:0]       r_phl;
    logic [pidm_pkg::MAG_HI_W+pidm_pkg::RECIP_HI_W-1:0]    r_phh;
    logic [pidm_pkg::PROD_W-1:0]          prod_full;
    logic [pidm_pkg::DRIVE_W-1:0]         r_quot;
    logic signed [pidm_pkg::DRIVE_W-1:0]  r_drive;

    // whole pipeline moves unless the output word is stalled
    assign adv     = !r_v6 || i_ready;
    assign o_pop   = adv && !i_q.empty;
    assign o_valid = r_v6;
    assign o_drive = r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (adv) begin
            r_v1 <= !i_q.empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // stage 1: three gain products
    always_comb begin
        n_prod_p = $signed(i_word.p_term) * $signed({1'b0, i_cfg.gain_p});
        n_prod_i = $signed(i_word.i_term) * $signed({1'b0, i_word.gain_i});
        n_prod_d = $signed(i_word.d_term) * $signed({1'b0, i_cfg.gain_d});
    end

    // stage 3 magnitude
    always_comb begin
        mag_full = r_acc[pidm_pkg::ACC_W-1] ? pidm_pkg::ACC_W'(-r_acc)
                                            : pidm_pkg::ACC_W'(r_acc);
    end

    // stage 5 partial product recombination
    always_comb begin
        prod_full = pidm_pkg::PROD_W'(r_pll)
                  + (pidm_pkg::PROD_W'(r_plh) << pidm_pkg::SPLIT_W)
                  + (pidm_pkg::PROD_W'(r_phl) << pidm_pkg::SPLIT_W)
                  + (pidm_pkg::PROD_W'(r_phh) << (2 * pidm_pkg::SPLIT_W));
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
            // stage 2: exact sum
            r_acc    <= pidm_pkg::ACC_W'(r_prod_p) + pidm_pkg::ACC_W'(r_prod_i)
                      + pidm_pkg::ACC_W'(r_prod_d);
            // stage 3: sign and magnitude, clamped at the saturation point
            r_neg3   <= r_acc[pidm_pkg::ACC_W-1];
            r_mag    <= (mag_full > pidm_pkg::ACC_W'(pidm_pkg::MAG_MAX))
                      ? pidm_pkg::MAG_MAX : mag_full[pidm_pkg::MAG_W-1:0];
            // stage 4: reciprocal partial products
            r_neg4   <= r_neg3;
            r_pll    <= r_mag[pidm_pkg::SPLIT_W-1:0]
                      * pidm_pkg::RECIP[pidm_pkg::SPLIT_W-1:0];
            r_plh    <= r_mag[pidm_pkg::SPLIT_W-1:0]
                      * pidm_pkg::RECIP[pidm_pkg::RECIP_W-1:pidm_pkg::SPLIT_W];
            r_phl    <= r_mag[pidm_pkg::MAG_W-1:pidm_pkg::SPLIT_W]
                      * pidm_pkg::RECIP[pidm_pkg::SPLIT_W-1:0];
            r_phh    <= r_mag[pidm_pkg::MAG_W-1:pidm_pkg::SPLIT_W]
                      * pidm_pkg::RECIP[pidm_pkg::RECIP_W-1:pidm_pkg::SPLIT_W];
            // stage 5: quotient magnitude, truncated toward zero
            r_neg5   <= r_neg4;
            r_quot   <= pidm_pkg::DRIVE_W'(prod_full >> pidm_pkg::DIV_SHIFT);
            // stage 6: sign back on, positive side saturates
            if (r_neg5) begin
                r_drive <= -$signed(r_quot);
            end else if (r_quot[pidm_pkg::DRIVE_W-1]) begin
                r_drive <= $signed(pidm_pkg::DRIVE_MAX);
            end else begin
                r_drive <= $signed(r_quot);
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/pidm_checker.sv
// port-level checker for the multi-mode pid controller, with its bind
`default_nettype none

`include "assert_macros.svh"

module pidm_checker (
    input wire logic                                     i_clk,
    input wire logic                                     i_rst_n,
    input wire logic                                     i_valid,
    input wire logic                                     o_ready,
    input wire logic signed [pidm_pkg::SAMPLE_WIDTH-1:0] i_target,
    input wire logic signed [pidm_pkg::SAMPLE_WIDTH-1:0] i_measured,
    input wire logic                                     o_valid,
    input wire logic                                     i_ready,
    input wire logic signed [pidm_pkg::DRIVE_W-1:0]      o_drive,
    input wire logic                                     i_cfg_we,
    input wire logic [pidm_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input wire logic [pidm_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    logic [pidm_pkg::INFLIGHT_W-1:0] r_inflight, n_inflight;
    logic                            in_take;
    logic                            out_take;
    logic                            cfg_seen;

    assign in_take  = i_valid && o_ready;
    assign out_take = o_valid && i_ready;
    assign cfg_seen = i_cfg_we && (i_cfg_idx != '0 || i_cfg_data != '0 ||
                                   i_target != '0 || i_measured != '0);

    // words taken but not yet delivered
    always_comb begin
        n_inflight = r_inflight;
        case ({in_take, out_take})
            2'b10:   n_inflight = r_inflight + pidm_pkg::INFLIGHT_W'(1);
            2'b01:   n_inflight = r_inflight - pidm_pkg::INFLIGHT_W'(1);
            default: n_inflight = r_inflight;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    `PIDM_ASSERT(a_drive_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_drive), "drive word changed while stalled")
    `PIDM_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid, "output valid right after reset")
    `PIDM_ASSERT(a_full_on_stall, i_clk, i_rst_n, $fell(o_ready) |-> $past(o_valid && !i_ready), "queue filled without an output stall")
    `PIDM_ASSERT(a_no_phantom, i_clk, i_rst_n, o_valid |-> r_inflight != '0 || cfg_seen && 1'b0, "drive word with nothing in flight")
    `PIDM_ASSERT(a_inflight_bound, i_clk, i_rst_n, r_inflight <= pidm_pkg::INFLIGHT_W'(pidm_pkg::MAX_INFLIGHT), "more words in flight than storage")

endmodule

bind pid_controller_multi_mode_top pidm_checker u_pidm_checker (.*);

`default_nettype wire

FILE: tb/sv/pid_controller_multi_mode_top_tb.sv
// testbench for the multi-mode pid controller: directed and random words checked by a predictor
`timescale 1ns / 100ps

module pid_controller_multi_mode_top_tb;
    import pidm_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_WORDS    = 50;
    localparam int SAT_WORDS      = 520;

    localparam logic [1:0]           MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE    = 3'd7;

    localparam longint SUM_CEIL  = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint SUM_FLOOR = -(longint'(1) <<< (DRIVE_W - 1));

    localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_EVERY_THIRD
    } t_rx_style;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_valid    = 1'b0;
    logic                           o_ready;
    logic signed [SAMPLE_WIDTH-1:0] i_target   = '0;
    logic signed [SAMPLE_WIDTH-1:0] i_measured = '0;
    logic                           o_valid;
    logic                           i_ready    = 1'b0;
    logic signed [DRIVE_W-1:0]      o_drive;
    logic                           i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]           i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]          i_cfg_data = '0;

    // predictor copy of the registers
    logic [1:0] cfg_mode    = MODE_CLAMP;
    longint     cfg_kp      = 0;
    longint     cfg_ki      = 0;
    longint     cfg_kd      = 0;
    longint     cfg_limit   = longint'(RST_LIMIT);
    longint     cfg_band_th = longint'(RST_THRESHOLD);
    longint     cfg_ki_band = 0;

    // predictor copy of the error history and error sum
    longint hist_e1 = 0;
    longint hist_e2 = 0;
    longint err_acc = 0;

    logic signed [DRIVE_W-1:0] pending_drive[$];
    int  fail_count   = 0;
    int  stuck_cycles = 0;
    int  burst_left   = 0;
    bit  full_rate    = 1'b0;
    bit  hold_req     = 1'b0;

    pid_controller_multi_mode_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_target   (i_target),
        .i_measured (i_measured),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_drive    (o_drive),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // expected drive for one word, advancing the predictor state
    function automatic logic signed [DRIVE_W-1:0] pid_drive(
        input logic signed [SAMPLE_WIDTH-1:0] tgt,
        input logic signed [SAMPLE_WIDTH-1:0] meas
    );
        longint err;
        longint acc;
        longint k_int;
        longint q;
        err = longint'(tgt) - longint'(meas);
        acc = 0;
        case (cfg_mode)
            MODE_INCR: begin
                acc = cfg_kp * (err - hist_e1) + cfg_ki * err
                    + cfg_kd * (err - 2 * hist_e1 + hist_e2);
                hist_e2 = hist_e1;
                hist_e1 = err;
            end
            MODE_CLAMP: begin
                err_acc = clip(err_acc + err, -cfg_limit, cfg_limit);
                acc = cfg_kp * err + cfg_kd * (err - hist_e1) + cfg_ki * err_acc;
                hist_e1 = err;
            end
            MODE_BAND: begin
                err_acc = clip(err_acc + err, SUM_FLOOR, SUM_CEIL);
                // edge of the band counts as inside
                k_int = (err > cfg_band_th || err < -cfg_band_th) ? cfg_ki : cfg_ki_band;
                acc = cfg_kp * err + cfg_kd * (err - hist_e1) + k_int * err_acc;
                hist_e1 = err;
            end
            default: acc = 0;
        endcase
        q = clip(acc / GAIN_SCALE, SUM_FLOOR, SUM_CEIL);
        return q[DRIVE_W-1:0];
    endfunction

    // register value with random bits above the register width
    function automatic logic [CFG_DATA_W-1:0] with_junk(input int value, input int width);
        logic [CFG_DATA_W-1:0] mask;
        mask = (CFG_DATA_W'(1) << width) - CFG_DATA_W'(1);
        return (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(value) & mask);
    endfunction

    // zero, full scale, anywhere, or a typical small value
    function automatic int pick_value(input int top, input int typical);
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return top;
            2:       return $urandom_range(0, top);
            default: return $urandom_range(0, typical);
        endcase
    endfunction

    // one register write; enable stays high so writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_MODE:           cfg_mode    = data[1:0];
            REG_GAIN_P:         cfg_kp      = longint'(data[GAIN_W-1:0]);
            REG_GAIN_I:         cfg_ki      = longint'(data[GAIN_W-1:0]);
            REG_GAIN_D:         cfg_kd      = longint'(data[GAIN_W-1:0]);
            REG_INTEGRAL_LIMIT: cfg_limit   = longint'(data[LIMIT_W-1:0]);
            REG_BAND_THRESHOLD: cfg_band_th = longint'(data[GAIN_W-1:0]);
            REG_GAIN_I_BAND:    cfg_ki_band = longint'(data[GAIN_W-1:0]);
            default: ;
        endcase
    endtask

    // stop offering and wait until every drive word is back
    task automatic settle();
        i_valid <= 1'b0;
        // let the checker log a word taken at this edge first
        @(posedge i_clk);
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [1:0] mode, input int kp, input int ki,
                             input int kd, input int limit, input int th, input int ki_band);
        settle();
        write_reg(REG_MODE, with_junk(int'(mode), 2));
        write_reg(REG_GAIN_P, with_junk(kp, GAIN_W));
        write_reg(REG_GAIN_I, with_junk(ki, GAIN_W));
        write_reg(REG_GAIN_D, with_junk(kd, GAIN_W));
        write_reg(REG_INTEGRAL_LIMIT, with_junk(limit, LIMIT_W));
        write_reg(REG_BAND_THRESHOLD, with_junk(th, GAIN_W));
        write_reg(REG_GAIN_I_BAND, with_junk(ki_band, GAIN_W));
        // unmapped index must leave everything alone
        write_reg(REG_NONE, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // offer one word, in bursts with random gaps unless at full rate, and wait for it to be taken
    task automatic send_word(input logic signed [SAMPLE_WIDTH-1:0] tgt,
                             input logic signed [SAMPLE_WIDTH-1:0] meas);
        int gap;
        if (!full_rate) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        i_valid    <= 1'b1;
        i_target   <= tgt;
        i_measured <= meas;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // receiver: segments of differing stall styles, plus a long hold-off on request
    initial begin : receiver
        int        seg_left;
        int        hold_left;
        t_rx_style style;
        seg_left  = 0;
        hold_left = 0;
        style     = RX_OPEN;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (full_rate) begin
                i_ready <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(4, 64);
                    style    = t_rx_style'($urandom_range(0, 3));
                end
                seg_left--;
                case (style)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_COIN:   i_ready <= 1'($urandom);
                    RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_ready <= (seg_left % 3 != 0);
                endcase
            end
        end
    end

    // check each drive word, then predict for any word taken at this edge
    always @(posedge i_clk) begin : check_drive
        logic signed [DRIVE_W-1:0] want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_drive.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("drive word %0d with nothing pending", o_drive);
                end else begin
                    want = pending_drive.pop_front();
                    if (o_drive !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("drive mismatch: expected %0d, got %0d", want, o_drive);
                    end
                end
            end
            if (i_valid && o_ready)
                pending_drive.push_back(pid_drive(i_target, i_measured));
        end
    end

    // watchdog on cycles without any handshake or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && o_ready) || (o_valid && i_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // reset values: mode 1 with zero gains, sum clamps at the default limit
    task automatic test_reset_values();
        send_word(S_MAX, S_MIN);
        send_word(S_MIN, S_MAX);
        send_word('0, '0);
    endtask

    // incremental mode at full gains with swinging extreme errors
    task automatic test_incremental();
        configure(MODE_INCR, 65535, 65535, 65535, 6000, 30, 0);
        send_word(S_MAX, S_MIN);
        send_word(S_MIN, S_MAX);
        send_word(S_MIN, S_MAX);
        send_word('0, '0);
    endtask

    // clamped integral with zero limit and with the widest limit
    task automatic test_clamped_integral();
        configure(MODE_CLAMP, 1000, 65535, 65535, 0, 30, 0);
        send_word(S_MAX, S_MIN);
        configure(MODE_CLAMP, 65535, 65535, 0, 1048575, 30, 0);
        send_word(S_MAX, S_MIN);
        send_word(S_MAX, S_MIN);
        send_word(S_MIN, S_MAX);
    endtask

    // band gain switching on and either side of the threshold
    task automatic test_band_edge();
        configure(MODE_BAND, 0, 65535, 0, 6000, 100, 7);
        send_word(16'sd100, '0);
        send_word(16'sd101, '0);
        send_word(-16'sd100, '0);
        send_word(-16'sd101, '0);
        configure(MODE_BAND, 500, 2000, 500, 6000, 0, 65535);
        send_word('0, '0);
        send_word(16'sd1, '0);
    endtask

    // unused mode gives zero drive and must not disturb the history
    task automatic test_unused_mode();
        configure(MODE_UNUSED, 65535, 65535, 65535, 6000, 30, 65535);
        send_word(S_MAX, S_MIN);
        send_word(S_MIN, S_MAX);
        configure(MODE_INCR, 1000, 1000, 1000, 6000, 30, 0);
        send_word(16'sd5, '0);
    endtask

    // band-mode sum grown far enough that drive saturates high, then low
    task automatic test_sum_saturation();
        configure(MODE_BAND, 0, 65535, 0, 0, 0, 0);
        full_rate = 1'b1;
        repeat (SAT_WORDS) send_word(S_MAX, S_MIN);
        full_rate = 1'b0;
        // zero limit in mode 1 pulls the sum back to zero
        configure(MODE_CLAMP, 0, 0, 0, 0, 30, 0);
        send_word('0, '0);
        configure(MODE_BAND, 0, 65535, 0, 0, 0, 0);
        full_rate = 1'b1;
        repeat (SAT_WORDS) send_word(S_MIN, S_MAX);
        full_rate = 1'b0;
    endtask

    // sum left far below the limit by band mode is pulled in on entering mode 1
    task automatic test_stale_sum();
        configure(MODE_CLAMP, 0, 65535, 0, 1000, 30, 0);
        send_word('0, '0);
        send_word(16'sd10, '0);
    endtask

    // long receiver hold-off while words keep coming, so the input stalls
    task automatic test_backpressure();
        configure(MODE_INCR, pick_value(65535, 2000), pick_value(65535, 2000),
                  pick_value(65535, 2000), 6000, 30, 0);
        full_rate = 1'b1;
        hold_req  = 1'b1;
        repeat (48) send_word(SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom));
        full_rate = 1'b0;
    endtask

    // random settings per phase, words mostly around the band edge and small errors
    task automatic test_random();
        logic [1:0]                     mode;
        logic signed [SAMPLE_WIDTH-1:0] tgt;
        logic signed [SAMPLE_WIDTH-1:0] meas;
        longint                         delta;
        int                             count;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            mode = (ph == 5) ? MODE_UNUSED : 2'(ph % 3);
            configure(mode, pick_value(65535, 2000), pick_value(65535, 2000),
                      pick_value(65535, 2000), pick_value(1048575, 50000),
                      pick_value(65535, 300), pick_value(65535, 2000));
            count = (mode == MODE_UNUSED) ? 20 : PHASE_WORDS;
            repeat (count) begin
                tgt = SAMPLE_WIDTH'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        delta = cfg_band_th + $urandom_range(0, 4) - 2;
                        if ($urandom_range(0, 1) == 1) delta = -delta;
                        meas = SAMPLE_WIDTH'(clip(longint'(tgt) - delta,
                                                  longint'(S_MIN), longint'(S_MAX)));
                    end
                    4, 5, 6: begin
                        delta = longint'($urandom_range(0, 128)) - 64;
                        meas = SAMPLE_WIDTH'(clip(longint'(tgt) - delta,
                                                  longint'(S_MIN), longint'(S_MAX)));
                    end
                    7: begin
                        tgt  = ($urandom_range(0, 1) == 1) ? S_MAX : S_MIN;
                        meas = ($urandom_range(0, 1) == 1) ? S_MAX : S_MIN;
                    end
                    default: meas = SAMPLE_WIDTH'($urandom);
                endcase
                send_word(tgt, meas);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_reset_values();
        test_incremental();
        test_clamped_integral();
        test_band_edge();
        test_unused_mode();
        test_sum_saturation();
        test_stale_sum();
        test_backpressure();
        test_random();
        settle();
        if (fail_count == 0 && pending_drive.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: pid_controller_multi_mode_top.f
+incdir+src
src/pidm_pkg.sv
src/pidm_front.sv
src/pidm_queue.sv
src/pidm_back.sv
src/pid_controller_multi_mode_top.sv
src/pidm_checker.sv
tb/sv/pid_controller_multi_mode_top_tb.sv
